FILE: rtl/lzwd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZ window decompressor.
// Depends on nothing; used by the top level and the checker.
package lzwd_pkg;

	localparam int HISTORY_DEPTH = 4096;
	localparam int MAX_COPY_LEN  = 16;
	localparam int COPY_CNT_W    = $clog2(MAX_COPY_LEN);
	localparam int OFFSET_W      = 12;
	localparam int LEN_W         = 20;
	localparam logic [LEN_W-1:0] LEN_SAT = '1;
	localparam int TDATA_W       = 32;
	localparam int TUSER_W       = 2;
	localparam logic [7:0] FLAG_PASSTHROUGH = 8'h01;
	localparam logic [4:0] CTRL_BITS        = 5'd16;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_BAD_OFS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_FLAG    = 3'd0,
		PH_CTRL_LO = 3'd1,
		PH_CTRL_HI = 3'd2,
		PH_ITEM    = 3'd3,
		PH_COPY2   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE = 2'd0,
		SQ_RD   = 2'd1,
		SQ_WR   = 2'd2
	} seq_t;

endpackage

FILE: rtl/lzwd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lz_window_decompressor.sv
`timescale 1ns / 1ps
// LZ window decompressor: one compressed byte per input beat, decompressed bytes out.
// Flag, control, literal and bad-offset bytes are each handled on acceptance, their result registered.
// A copy item reads history for each output byte (SQ_RD), then writes it back and outputs it
// (SQ_WR); no input is accepted until the copy ends, and a stalled result beat holds SQ_WR.
// arst_n clears the sequencer, decoder phase, counters and output valid; history is not cleared.
// Depends on lzwd_pkg and lzwd_ram.
module lz_window_decompressor #(
	parameter int HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side; s_tdata: [7:0] in_byte; s_tlast: last_in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	// master side; m_tdata: [7:0] out_byte, [9:8] status, [29:10] total_length, [31:30] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lzwd_pkg::TDATA_W-1:0]  m_tdata,
	// m_tlast: last_of_run
	output logic                          m_tlast,
	// m_tuser: [0] has_data, [1] end_of_block
	output logic [lzwd_pkg::TUSER_W-1:0]  m_tuser
);

	localparam int AW = $clog2(HISTORY_DEPTH);

	// Sequencer and decoder state
	lzwd_pkg::seq_t   seq_q, seq_d;
	lzwd_pkg::phase_t phase_q, phase_d;
	logic [AW-1:0]                  wpos_q, wpos_d;
	logic [AW-1:0]                  src_q, src_d;
	logic [lzwd_pkg::LEN_W-1:0]     bw_q, bw_d;
	logic [15:0]                    cw_q, cw_d;
	logic [4:0]                     cl_q, cl_d;
	logic [7:0]                     ifb_q, ifb_d;
	logic                           pass_q, pass_d;
	logic [lzwd_pkg::COPY_CNT_W-1:0] cnt_q, cnt_d;
	logic                           last_q, last_d;

	// Output register
	logic                           out_v_q;
	logic [7:0]                     out_byte_q;
	logic                           has_data_q;
	logic                           tlast_q;
	logic                           eob_q;
	lzwd_pkg::status_t              status_q;
	logic [lzwd_pkg::LEN_W-1:0]     total_q;

	// Next output values
	logic                           load_out;
	logic [7:0]                     o_byte;
	logic                           o_has;
	logic                           o_tlast;
	logic                           o_eob;
	lzwd_pkg::status_t              o_status;
	logic [lzwd_pkg::LEN_W-1:0]     o_total;

	// History RAM
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// Helpers
	logic                       accept;
	logic                       out_free;
	logic [lzwd_pkg::LEN_W-1:0] bw_inc;
	logic [15:0]                ni_cw;
	logic [4:0]                 ni_cl;
	lzwd_pkg::phase_t           ni_phase;
	logic [lzwd_pkg::OFFSET_W-1:0] offset;
	logic                       bad_ofs;
	logic                       emit;
	logic                       go_copy;
	lzwd_pkg::status_t          st;

	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The output register frees up when it is empty or its beat is taken this cycle
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (seq_q == lzwd_pkg::SQ_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// Saturating count of bytes produced in this block
	assign bw_inc = (bw_q == lzwd_pkg::LEN_SAT) ? bw_q : bw_q + 1'b1;

	// Advance to the next control bit
	assign ni_cw    = {1'b0, cw_q[15:1]};
	assign ni_cl    = (cl_q != 5'd0) ? cl_q - 5'd1 : 5'd0;
	assign ni_phase = (ni_cl == 5'd0) ? lzwd_pkg::PH_CTRL_LO : lzwd_pkg::PH_ITEM;

	// Copy offset from the item's two bytes; reject zero or reaching before block start
	assign offset  = {ifb_q[7:4], s_tdata};
	assign bad_ofs = (offset == '0) || (lzwd_pkg::LEN_W'(offset) > bw_q);

	always_comb begin
		seq_d     = seq_q;
		phase_d   = phase_q;
		wpos_d    = wpos_q;
		src_d     = src_q;
		bw_d      = bw_q;
		cw_d      = cw_q;
		cl_d      = cl_q;
		ifb_d     = ifb_q;
		pass_d    = pass_q;
		cnt_d     = cnt_q;
		last_d    = last_q;
		ram_we    = 1'b0;
		ram_waddr = wpos_q;
		ram_wdata = s_tdata;
		ram_re    = 1'b0;
		ram_raddr = src_q;
		load_out  = 1'b0;
		o_byte    = 8'h00;
		o_has     = 1'b0;
		o_tlast   = 1'b1;
		o_eob     = 1'b0;
		o_status  = lzwd_pkg::ST_OK;
		o_total   = '0;
		emit      = 1'b0;
		go_copy   = 1'b0;
		st        = lzwd_pkg::ST_OK;

		unique case (seq_q)
			lzwd_pkg::SQ_IDLE: begin
				if (accept) begin
					unique case (phase_q)
						lzwd_pkg::PH_FLAG: begin
							pass_d  = (s_tdata == lzwd_pkg::FLAG_PASSTHROUGH);
							cl_d    = 5'd0;
							cw_d    = 16'h0000;
							phase_d = pass_d ? lzwd_pkg::PH_ITEM : lzwd_pkg::PH_CTRL_LO;
						end
						lzwd_pkg::PH_CTRL_LO: begin
							cw_d    = {8'h00, s_tdata};
							phase_d = lzwd_pkg::PH_CTRL_HI;
							if (s_tlast) begin
								st = lzwd_pkg::ST_TRUNC;
							end
						end
						lzwd_pkg::PH_CTRL_HI: begin
							cw_d    = {s_tdata, cw_q[7:0]};
							cl_d    = lzwd_pkg::CTRL_BITS;
							phase_d = lzwd_pkg::PH_ITEM;
						end
						lzwd_pkg::PH_ITEM: begin
							if (pass_q) begin
								emit = 1'b1;
							end else if (!cw_q[0]) begin
								emit    = 1'b1;
								cw_d    = ni_cw;
								cl_d    = ni_cl;
								phase_d = ni_phase;
							end else begin
								// first byte of a copy item: hold it for the offset
								ifb_d   = s_tdata;
								phase_d = lzwd_pkg::PH_COPY2;
								if (s_tlast) begin
									st = lzwd_pkg::ST_TRUNC;
								end
							end
						end
						lzwd_pkg::PH_COPY2: begin
							if (bad_ofs) begin
								st = lzwd_pkg::ST_BAD_OFS;
							end else begin
								go_copy = 1'b1;
							end
							cw_d    = ni_cw;
							cl_d    = ni_cl;
							phase_d = ni_phase;
						end
						default: begin
							phase_d = lzwd_pkg::PH_FLAG;
						end
					endcase

					if (emit) begin
						// literal or pass-through byte: store in history and send on
						ram_we = 1'b1;
						wpos_d = wpos_q + 1'b1;
						bw_d   = bw_inc;
					end

					// a copy reports the block end on its own last byte
					if ((emit || s_tlast || (st != lzwd_pkg::ST_OK)) && !go_copy) begin
						load_out = 1'b1;
						o_byte   = emit ? s_tdata : 8'h00;
						o_has    = emit;
						o_status = st;
						o_eob    = s_tlast;
						if (s_tlast) begin
							o_total = emit ? bw_inc : bw_q;
						end
					end

					if (go_copy) begin
						src_d  = wpos_q - AW'(offset);
						cnt_d  = ifb_q[lzwd_pkg::COPY_CNT_W-1:0];
						last_d = s_tlast;
						seq_d  = lzwd_pkg::SQ_RD;
					end

					// Block end: expect a new flag byte; a pending copy clears the
					// position and count when it finishes
					if (s_tlast) begin
						phase_d = lzwd_pkg::PH_FLAG;
						cw_d    = 16'h0000;
						cl_d    = 5'd0;
						ifb_d   = 8'h00;
						pass_d  = 1'b0;
						if (!go_copy) begin
							wpos_d = '0;
							bw_d   = '0;
						end
					end
				end
			end
			lzwd_pkg::SQ_RD: begin
				ram_re = 1'b1;
				seq_d  = lzwd_pkg::SQ_WR;
			end
			lzwd_pkg::SQ_WR: begin
				// hold the read byte until the output register has room
				if (out_free) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					wpos_d    = wpos_q + 1'b1;
					bw_d      = bw_inc;
					src_d     = src_q + 1'b1;
					load_out  = 1'b1;
					o_byte    = ram_rdata;
					o_has     = 1'b1;
					o_tlast   = (cnt_q == '0);
					o_eob     = (cnt_q == '0) && last_q;
					if ((cnt_q == '0) && last_q) begin
						o_total = bw_inc;
					end
					if (cnt_q == '0) begin
						seq_d = lzwd_pkg::SQ_IDLE;
						if (last_q) begin
							wpos_d = '0;
							bw_d   = '0;
						end
					end else begin
						cnt_d = cnt_q - 1'b1;
						seq_d = lzwd_pkg::SQ_RD;
					end
				end
			end
			default: begin
				seq_d = lzwd_pkg::SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= lzwd_pkg::SQ_IDLE;
			phase_q <= lzwd_pkg::PH_FLAG;
			wpos_q  <= '0;
			src_q   <= '0;
			bw_q    <= '0;
			cw_q    <= '0;
			cl_q    <= '0;
			ifb_q   <= '0;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			seq_q   <= seq_d;
			phase_q <= phase_d;
			wpos_q  <= wpos_d;
			src_q   <= src_d;
			bw_q    <= bw_d;
			cw_q    <= cw_d;
			cl_q    <= cl_d;
			ifb_q   <= ifb_d;
			pass_q  <= pass_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output payload: no reset needed
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= o_byte;
			has_data_q <= o_has;
			tlast_q    <= o_tlast;
			eob_q      <= o_eob;
			status_q   <= o_status;
			total_q    <= o_total;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, total_q, status_q, out_byte_q};
	assign m_tlast  = tlast_q;
	assign m_tuser  = {eob_q, has_data_q};

endmodule

FILE: rtl/lzwd_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the LZ window decompressor's result stream, with its bind.
// Depends on lzwd_pkg and lz_window_decompressor.
module lzwd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [lzwd_pkg::TDATA_W-1:0] m_tdata,
	input logic                         m_tlast,
	input logic [lzwd_pkg::TUSER_W-1:0] m_tuser
);

	// a stalled beat holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a beat without data only closes a run
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("empty result beat not marked last of run");

	// end of block only on the last beat of a run
	a_eob_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("end of block on a beat that is not last of run");

	// total length only reported at end of block
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> (m_tdata[29:10] == '0))
		else $error("total length outside end of block");

	// inner copy beats carry data and clean status
	a_inner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0] && (m_tdata[9:8] == lzwd_pkg::ST_OK))
		else $error("inner beat without data or with status");

endmodule

bind lz_window_decompressor lzwd_checker u_lzwd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

FILE: tb/lz_window_decompressor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lz_window_decompressor: directed blocks, then random streams.
// Depends on lzwd_pkg and the RTL of the block only.
module lz_window_decompressor_test;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BEATS = 265;
	localparam int QUIET_FROM   = 215;   // no idling on either side from here on
	localparam int HOLD_AT      = 40;
	localparam int DRAIN_AT     = 160;
	localparam int LONG_HOLD    = 300;
	localparam int LONG_BLOCK   = 120;
	localparam int DRAIN_CYCLES = 40;    // idle margin after the last owed beat
	localparam int MAX_REPORTS  = 20;

	// One output beat, as the decoder should present it.
	typedef struct packed {
		logic [7:0]          data;
		logic                has_data;
		logic                run_end;
		logic                blk_end;
		lzwd_pkg::status_t   st;
		logic [19:0]         total;
	} out_beat_t;

	// One row of the directed table; typed rows carry their single result inline.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		out_beat_t  want;
	} stim_row_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic [7:0]                     s_tdata  = 8'h00;
	logic                           s_tlast  = 1'b0;
	logic                           m_tready = 1'b0;
	logic                           s_tready;
	logic                           m_tvalid;
	logic [lzwd_pkg::TDATA_W-1:0]   m_tdata;  // [7:0] out_byte, [9:8] status, [29:10] total
	logic                           m_tlast;  // last_of_run
	logic [lzwd_pkg::TUSER_W-1:0]   m_tuser;  // [0] has_data, [1] end_of_block

	lz_window_decompressor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder state as seen by the bench
	// ------------------------------------------------------------------
	logic [7:0]        hist [lzwd_pkg::HISTORY_DEPTH];
	logic [11:0]       dec_wpos;
	logic [19:0]       dec_bytes;
	logic [15:0]       cword;
	logic [4:0]        cleft;
	lzwd_pkg::phase_t  dec_phase;
	logic [7:0]        first_b;
	logic              pass_mode;

	out_beat_t   step_beats[$];   // beats caused by the byte just decoded
	out_beat_t   due_beats[$];    // beats still owed by the block, oldest first
	stim_row_t   directed_rows[$];
	logic [11:0] planned_ofs;     // offset chosen for the copy item in flight

	int err_count    = 0;
	int beats_in     = 0;
	int beats_out    = 0;
	int blocks_seen  = 0;
	int pass_blocks  = 0;
	int bad_ofs_seen = 0;
	int trunc_seen   = 0;
	int cycle_count  = 0;

	// Receiver and sender coordination
	int   hold_left  = 0;
	int   burst_left = 0;
	logic hold_armed = 1'b0;
	logic hold_done  = 1'b0;
	logic quiet      = 1'b0;

	// Render a beat's fields for a report line.
	function automatic string beat_str(input out_beat_t ob);
		return $sformatf("byte %h data %b run_end %b blk_end %b status %0d total %0d",
			ob.data, ob.has_data, ob.run_end, ob.blk_end, ob.st, ob.total);
	endfunction

	// Append a data byte to the history and owe a plain data beat for it.
	task automatic emit_byte(input logic [7:0] v);
		out_beat_t ob;
		ob = '0;
		ob.data = v;
		ob.has_data = 1'b1;
		hist[dec_wpos] = v;
		dec_wpos = dec_wpos + 12'd1;
		if (dec_bytes != lzwd_pkg::LEN_SAT)
			dec_bytes = dec_bytes + 20'd1;
		step_beats.push_back(ob);
	endtask

	// Consume one control bit; fetch a fresh control word once all are used.
	task automatic next_item();
		cword = cword >> 1;
		if (cleft != 5'd0)
			cleft = cleft - 5'd1;
		dec_phase = (cleft == 5'd0) ? lzwd_pkg::PH_CTRL_LO : lzwd_pkg::PH_ITEM;
	endtask

	// Advance the decoder by one compressed byte and collect the beats it owes.
	task automatic decode_byte(input logic [7:0] b, input logic last_in);
		logic [11:0]        ofs;
		logic [4:0]         len;
		logic [11:0]        src;
		lzwd_pkg::status_t  st;
		out_beat_t          tail;
		st = lzwd_pkg::ST_OK;
		step_beats.delete();
		case (dec_phase)
		lzwd_pkg::PH_FLAG: begin
			pass_mode = (b == lzwd_pkg::FLAG_PASSTHROUGH);
			cword = 16'h0000;
			cleft = 5'd0;
			dec_phase = pass_mode ? lzwd_pkg::PH_ITEM : lzwd_pkg::PH_CTRL_LO;
			blocks_seen++;
			if (pass_mode)
				pass_blocks++;
		end
		lzwd_pkg::PH_CTRL_LO: begin
			cword = {8'h00, b};
			dec_phase = lzwd_pkg::PH_CTRL_HI;
			if (last_in)
				st = lzwd_pkg::ST_TRUNC;
		end
		lzwd_pkg::PH_CTRL_HI: begin
			cword[15:8] = b;
			cleft = lzwd_pkg::CTRL_BITS;
			dec_phase = lzwd_pkg::PH_ITEM;
		end
		lzwd_pkg::PH_ITEM: begin
			if (pass_mode) begin
				emit_byte(b);
			end else if (!cword[0]) begin
				emit_byte(b);
				next_item();
			end else begin
				first_b = b;
				dec_phase = lzwd_pkg::PH_COPY2;
				if (last_in)
					st = lzwd_pkg::ST_TRUNC;
			end
		end
		default: begin
			// second byte of a copy: offset high nibble came with the first byte
			ofs = {first_b[7:4], b};
			len = {1'b0, first_b[3:0]} + 5'd1;
			if (ofs == 12'd0 || {8'h00, ofs} > dec_bytes) begin
				st = lzwd_pkg::ST_BAD_OFS;
			end else begin
				// read one byte at a time so overlapping copies repeat
				src = dec_wpos - ofs;
				repeat (len) begin
					emit_byte(hist[src]);
					src = src + 12'd1;
				end
			end
			next_item();
		end
		endcase

		if (step_beats.size() == 0 && (last_in || st != lzwd_pkg::ST_OK)) begin
			tail = '0;
			step_beats.push_back(tail);
		end
		if (step_beats.size() != 0) begin
			tail = step_beats.pop_back();
			tail.run_end = 1'b1;
			tail.st = st;
			if (last_in) begin
				tail.blk_end = 1'b1;
				tail.total = dec_bytes;
			end
			step_beats.push_back(tail);
		end
		if (st == lzwd_pkg::ST_BAD_OFS)
			bad_ofs_seen++;
		if (st == lzwd_pkg::ST_TRUNC)
			trunc_seen++;

		if (last_in) begin
			dec_phase = lzwd_pkg::PH_FLAG;
			dec_wpos = 12'd0;
			dec_bytes = 20'd0;
			cword = 16'h0000;
			cleft = 5'd0;
			first_b = 8'h00;
			pass_mode = 1'b0;
		end
	endtask

	// Choose the next byte from where the decoder stands, so that most
	// streams are well formed: valid offsets, with some noise mixed in.
	function automatic logic [7:0] pick_byte(input logic allow_pass);
		int unsigned reach;
		logic [3:0]  len_nib;
		logic [7:0]  v;
		reach = (dec_bytes > 20'd4095) ? 4095 : dec_bytes;
		len_nib = 4'($urandom_range(15, 0));
		v = 8'($urandom_range(255, 0));
		case (dec_phase)
		lzwd_pkg::PH_FLAG: begin
			if (allow_pass && $urandom_range(4, 0) == 0)
				v = lzwd_pkg::FLAG_PASSTHROUGH;
			else if (v == lzwd_pkg::FLAG_PASSTHROUGH)
				v = 8'h00;
		end
		lzwd_pkg::PH_ITEM: begin
			if (!pass_mode && cword[0]) begin
				if (reach == 0 || $urandom_range(9, 0) == 0)
					planned_ofs = 12'($urandom_range(4095, 0));
				else if ($urandom_range(1, 0) == 0)
					planned_ofs = 12'($urandom_range((reach < 16) ? reach : 16, 1));
				else
					planned_ofs = 12'($urandom_range(reach, 1));
				v = {planned_ofs[11:8], len_nib};
			end
		end
		lzwd_pkg::PH_COPY2: begin
			if ($urandom_range(11, 0) != 0)
				v = planned_ofs[7:0];
		end
		default: ;
		endcase
		return v;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic l);
		stim_row_t r;
		r = '0;
		r.data = b;
		r.last = l;
		directed_rows.push_back(r);
	endtask

	task automatic add_known(input logic [7:0] b, input logic l, input logic [7:0] d,
			input logic hd, input logic be, input lzwd_pkg::status_t st, input int total);
		stim_row_t r;
		r = '0;
		r.data = b;
		r.last = l;
		r.typed = 1'b1;
		r.want.data = d;
		r.want.has_data = hd;
		r.want.run_end = 1'b1;
		r.want.blk_end = be;
		r.want.st = st;
		r.want.total = 20'(total);
		directed_rows.push_back(r);
	endtask

	// Offer one beat, hold it until taken, then book what it owes.
	task automatic send_beat(input logic [7:0] b, input logic l, input logic typed,
			input out_beat_t want);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_byte(b, l);
		if (typed)
			due_beats.push_back(want);
		else
			foreach (step_beats[i])
				due_beats.push_back(step_beats[i]);
		beats_in++;
	endtask

	// Drop valid and wait for every owed beat to come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random ready bursts, plus one long hold to back the block up
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left--;
		end else if (!quiet && $urandom_range(3, 0) == 0) begin
			m_tready <= 1'b0;
			burst_left = $urandom_range(9, 0);
		end else begin
			m_tready <= 1'b1;
			burst_left = $urandom_range(20, 0);
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each taken output beat with the oldest owed one
	// ------------------------------------------------------------------
	out_beat_t got_beat;
	out_beat_t owed_beat;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat.data     = m_tdata[7:0];
			got_beat.st       = lzwd_pkg::status_t'(m_tdata[9:8]);
			got_beat.total    = m_tdata[29:10];
			got_beat.run_end  = m_tlast;
			got_beat.has_data = m_tuser[0];
			got_beat.blk_end  = m_tuser[1];
			beats_out++;
			if (due_beats.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: beat with nothing owed: expected none, got %s",
						$time, beat_str(got_beat));
			end else begin
				owed_beat = due_beats.pop_front();
				if (got_beat !== owed_beat) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: beat mismatch: expected %s, got %s",
							$time, beat_str(owed_beat), beat_str(got_beat));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lz_window_decompressor verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int        sent;
		int        blk_no;
		int        blk_len;
		logic [7:0] b;
		logic       l;

		for (int i = 0; i < lzwd_pkg::HISTORY_DEPTH; i++)
			hist[i] = 8'h00;
		dec_wpos = 12'd0;
		dec_bytes = 20'd0;
		cword = 16'h0000;
		cleft = 5'd0;
		dec_phase = lzwd_pkg::PH_FLAG;
		first_b = 8'h00;
		pass_mode = 1'b0;
		planned_ofs = 12'd0;

		// Empty compressed block: flag only
		add_known(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, lzwd_pkg::ST_OK, 0);
		// Passthrough block with extreme bytes
		add_row(8'h01, 1'b0);
		add_known(8'h00, 1'b0, 8'h00, 1'b1, 1'b0, lzwd_pkg::ST_OK, 0);
		add_known(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, lzwd_pkg::ST_OK, 2);
		// Compressed: literal, overlapping full-length copy, zero offset,
		// offset beyond the data, copy from the very start, then a cut item
		add_row(8'h02, 1'b0);
		add_row(8'hFE, 1'b0);
		add_row(8'hFF, 1'b0);
		add_known(8'hA5, 1'b0, 8'hA5, 1'b1, 1'b0, lzwd_pkg::ST_OK, 0);
		add_row(8'h0F, 1'b0);
		add_row(8'h01, 1'b0);
		add_row(8'h00, 1'b0);
		add_known(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, lzwd_pkg::ST_BAD_OFS, 0);
		add_row(8'hF0, 1'b0);
		add_known(8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, lzwd_pkg::ST_BAD_OFS, 0);
		add_row(8'h01, 1'b0);
		add_row(8'h11, 1'b0);
		add_known(8'h3F, 1'b1, 8'h00, 1'b0, 1'b1, lzwd_pkg::ST_TRUNC, 19);
		// Block cut on a lone control low byte
		add_row(8'hFF, 1'b0);
		add_known(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, lzwd_pkg::ST_TRUNC, 0);
		// Block ending right after a full control word
		add_row(8'h80, 1'b0);
		add_row(8'h00, 1'b0);
		add_known(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, lzwd_pkg::ST_OK, 0);
		// Block ending right after a complete literal
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h80, 1'b0);
		add_known(8'h5A, 1'b1, 8'h5A, 1'b1, 1'b1, lzwd_pkg::ST_OK, 1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].data, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].want);
		// pause the sender until the directed part has fully drained
		wait_drained();

		// Random blocks; the third is long and compressed to reach far offsets
		sent = 0;
		blk_no = 0;
		while (sent < RANDOM_BEATS) begin
			blk_len = (blk_no == 2) ? LONG_BLOCK : $urandom_range(40, 1);
			for (int k = 0; k < blk_len; k++) begin
				quiet = (sent >= QUIET_FROM);
				if (sent == HOLD_AT)
					hold_armed = 1'b1;
				if (sent == DRAIN_AT)
					wait_drained();
				b = pick_byte(blk_no != 2);
				l = (k == blk_len - 1);
				send_beat(b, l, 1'b0, '0);
				sent++;
				if (!quiet && hold_left == 0 && $urandom_range(4, 0) == 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(10, 1)) @(posedge clk);
				end
			end
			blk_no++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d input beats over %0d blocks (%0d passthrough), %0d output beats.",
			beats_in, blocks_seen, pass_blocks, beats_out);
		$display("Bad offsets flagged: %0d, truncated ends: %0d.", bad_ofs_seen, trunc_seen);
		if (err_count == 0) begin
			$display("lz_window_decompressor verification clean");
		end else begin
			$display("lz_window_decompressor verification failed");
		end
		$finish;
	end

endmodule
